### hdl/esmv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ELLPACK sparse matrix-vector multiply package
// Shared types, codes and constants for the sparse matrix-vector block.
// ----------------------------------------------------------------------------
package esmv_pkg;

   // Default sizes of the stores.
   localparam int MAX_ROWS_DEF  = 1024;
   localparam int MAX_SLOTS_DEF = 16;
   localparam int MAX_COLS_DEF  = 1024;

   // Widths of the fields and of the internal command.
   localparam int CmdAddrWidth = 24;   // holds row * slots + slot at the largest sizes
   localparam int SlotLimWidth = 9;    // holds a slot count up to 256
   localparam int CsrWidth     = 11;

   // Register reset values.
   localparam logic [10:0] NUM_ROWS_RST      = 11'd1024;
   localparam logic [10:0] NUM_COLS_RST      = 11'd1024;
   localparam logic [4:0]  SLOTS_PER_ROW_RST = 5'd16;
   localparam logic [10:0] VECTOR_LENGTH_RST = 11'd1024;

   // Register indexes.
   localparam logic [1:0] CSR_NUM_ROWS      = 2'd0;
   localparam logic [1:0] CSR_NUM_COLS      = 2'd1;
   localparam logic [1:0] CSR_SLOTS_PER_ROW = 2'd2;
   localparam logic [1:0] CSR_VECTOR_LENGTH = 2'd3;

   // Function codes of an input transaction.
   localparam logic [1:0] FUNC_LOAD_SLOT   = 2'd0;
   localparam logic [1:0] FUNC_LOAD_VECTOR = 2'd1;
   localparam logic [1:0] FUNC_COMPUTE     = 2'd2;
   localparam logic [1:0] FUNC_RESERVED    = 2'd3;

   typedef struct packed {
      logic [1:0]         func;
      logic [9:0]         row;
      logic [3:0]         slot;
      logic [9:0]         column;
      logic               slot_used;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [9:0]         row_index;
      logic signed [47:0] row_sum;
      logic               size_error;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_SLOT,
      OP_VECTOR,
      OP_ROW
   } op_type;

   // Classified command handed from the front to the back.
   typedef struct packed {
      op_type                    op;
      logic [CmdAddrWidth-1:0]   addr;
      logic [9:0]                row;
      logic [9:0]                column;
      logic                      slot_used;
      logic signed [31:0]        value;
      logic [SlotLimWidth-1:0]   slot_lim;
      logic                      size_err;
   } cmd_type;

   // Status from the back to the front.
   typedef struct packed {
      logic pop;
      logic clearing;
   } back_status_type;

   // Slot store word.
   typedef struct packed {
      logic               used;
      logic [9:0]         column;
      logic signed [31:0] value;
   } slot_word_type;

   localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;

endpackage
`default_nettype wire

### hdl/esmv_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module esmv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AddrWidth = ($clog2(DEPTH) > 0) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AddrWidth-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [AddrWidth-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

### hdl/esmv_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse matrix-vector front end
// Holds the configuration, checks and classifies input transactions and
// queues the accepted commands for the back end.
// ----------------------------------------------------------------------------
module esmv_front #(
   parameter int MAX_ROWS  = esmv_pkg::MAX_ROWS_DEF,
   parameter int MAX_SLOTS = esmv_pkg::MAX_SLOTS_DEF,
   parameter int MAX_COLS  = esmv_pkg::MAX_COLS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire esmv_pkg::req_type       req_data,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [1:0]              csr_index,
   input  wire logic [esmv_pkg::CsrWidth-1:0] csr_data,
   output logic                         q_valid,
   output esmv_pkg::cmd_type            q_cmd,
   input  wire esmv_pkg::back_status_type back_status
);

   logic [10:0] num_rows_ff, num_rows_in;
   logic [10:0] num_cols_ff, num_cols_in;
   logic [4:0]  slots_per_row_ff, slots_per_row_in;
   logic [10:0] vector_length_ff, vector_length_in;

   esmv_pkg::cmd_type q_mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   logic              row_ok, slot_ok, col_ok, vec_ok;
   logic              push, accept;
   esmv_pkg::cmd_type cmd;

   assign csr_ready = 1'b1;

   // Configuration register writes.
   always_comb begin
      num_rows_in      = num_rows_ff;
      num_cols_in      = num_cols_ff;
      slots_per_row_in = slots_per_row_ff;
      vector_length_in = vector_length_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            esmv_pkg::CSR_NUM_ROWS:      num_rows_in      = csr_data;
            esmv_pkg::CSR_NUM_COLS:      num_cols_in      = csr_data;
            esmv_pkg::CSR_SLOTS_PER_ROW: slots_per_row_in = csr_data[4:0];
            esmv_pkg::CSR_VECTOR_LENGTH: vector_length_in = csr_data;
         endcase
      end
   end

   // Range checks against the configuration and the store sizes.
   assign row_ok  = (32'(req_data.row) < 32'(num_rows_ff)) && (32'(req_data.row) < MAX_ROWS);
   assign slot_ok = (32'(req_data.slot) < 32'(slots_per_row_ff))
                    && (32'(req_data.slot) < MAX_SLOTS);
   assign col_ok  = (32'(req_data.column) < 32'(num_cols_ff))
                    && (32'(req_data.column) < MAX_COLS);
   assign vec_ok  = (32'(req_data.column) < 32'(vector_length_ff))
                    && (32'(req_data.column) < MAX_COLS);

   // Classify the transaction into a command; dropped ones are never queued.
   always_comb begin
      cmd.row       = req_data.row;
      cmd.column    = req_data.column;
      cmd.slot_used = req_data.slot_used;
      cmd.value     = req_data.value;
      cmd.size_err  = (num_cols_ff != vector_length_ff);
      if (32'(slots_per_row_ff) < MAX_SLOTS) begin
         cmd.slot_lim = esmv_pkg::SlotLimWidth'(slots_per_row_ff);
      end else begin
         cmd.slot_lim = esmv_pkg::SlotLimWidth'(MAX_SLOTS);
      end
      cmd.addr = esmv_pkg::CmdAddrWidth'(32'(req_data.row) * MAX_SLOTS);
      cmd.op   = esmv_pkg::OP_ROW;
      push     = 1'b0;
      unique case (req_data.func)
         esmv_pkg::FUNC_LOAD_SLOT: begin
            cmd.op   = esmv_pkg::OP_SLOT;
            cmd.addr = esmv_pkg::CmdAddrWidth'(32'(req_data.row) * MAX_SLOTS
                                               + 32'(req_data.slot));
            push     = row_ok && slot_ok && (!req_data.slot_used || col_ok);
         end
         esmv_pkg::FUNC_LOAD_VECTOR: begin
            cmd.op = esmv_pkg::OP_VECTOR;
            push   = vec_ok;
         end
         esmv_pkg::FUNC_COMPUTE: begin
            cmd.op = esmv_pkg::OP_ROW;
            push   = row_ok;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   // Two-entry command queue.
   assign req_stall = back_status.clearing || (count_ff == 2'd2);
   assign accept    = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign q_cmd     = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept && push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (back_status.pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      count_in = count_ff + 2'(accept && push) - 2'(back_status.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff      <= esmv_pkg::NUM_ROWS_RST;
         num_cols_ff      <= esmv_pkg::NUM_COLS_RST;
         slots_per_row_ff <= esmv_pkg::SLOTS_PER_ROW_RST;
         vector_length_ff <= esmv_pkg::VECTOR_LENGTH_RST;
         wr_ptr_ff        <= 1'b0;
         rd_ptr_ff        <= 1'b0;
         count_ff         <= 2'd0;
      end else begin
         num_rows_ff      <= num_rows_in;
         num_cols_ff      <= num_cols_in;
         slots_per_row_ff <= slots_per_row_in;
         vector_length_ff <= vector_length_in;
         wr_ptr_ff        <= wr_ptr_in;
         rd_ptr_ff        <= rd_ptr_in;
         count_ff         <= count_in;
      end
      if (accept && push) begin
         q_mem_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule
`default_nettype wire

### hdl/esmv_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse matrix-vector back end
// Owns the slot and vector stores, clears the used marks after reset, runs
// loads and streams one slot a cycle through a multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
module esmv_back #(
   parameter int MAX_ROWS  = esmv_pkg::MAX_ROWS_DEF,
   parameter int MAX_SLOTS = esmv_pkg::MAX_SLOTS_DEF,
   parameter int MAX_COLS  = esmv_pkg::MAX_COLS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_valid,
   input  wire esmv_pkg::cmd_type q_cmd,
   output esmv_pkg::back_status_type back_status,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output esmv_pkg::rsp_type      rsp_data
);

   localparam int SlotDepth = MAX_ROWS * MAX_SLOTS;
   localparam int SlotAw    = ($clog2(SlotDepth) > 0) ? $clog2(SlotDepth) : 1;
   localparam int VecAw     = ($clog2(MAX_COLS) > 0) ? $clog2(MAX_COLS) : 1;
   localparam int SlotWidth = $bits(esmv_pkg::slot_word_type);
   localparam int LimW      = esmv_pkg::SlotLimWidth;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RUN,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [SlotAw-1:0] clr_ff, clr_in;
   logic [SlotAw-1:0] base_ff, base_in;
   logic [LimW-1:0]   lim_ff, lim_in;
   logic [LimW-1:0]   j_ff, j_in;
   logic [9:0]        row_ff, row_in;
   logic              err_ff, err_in;
   logic signed [47:0] sum_ff, sum_in;
   logic              s1_ff, s1_in;
   logic              s2_ff, s2_in;
   logic signed [31:0] s2_val_ff;
   logic              s3_ff, s3_in;
   logic signed [63:0] s3_prod_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   esmv_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                   pop, issue;
   logic                   slot_we, vec_we;
   logic [SlotAw-1:0]      slot_waddr;
   esmv_pkg::slot_word_type slot_wdata, slot_rdata;
   logic [SlotWidth-1:0]   slot_rbits;
   logic [31:0]            vec_rdata;
   logic                   s2_use;
   logic signed [47:0]     prod_q;
   logic signed [48:0]     acc;
   logic signed [47:0]     acc_sat;

   // Stores.
   esmv_ram #(.WIDTH(SlotWidth), .DEPTH(SlotDepth)) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_en   (issue),
      .rd_addr (base_ff + SlotAw'(j_ff)),
      .rd_data (slot_rbits)
   );
   assign slot_rdata = esmv_pkg::slot_word_type'(slot_rbits);

   esmv_ram #(.WIDTH(32), .DEPTH(MAX_COLS)) u_vec_ram (
      .clock   (clock),
      .wr_en   (vec_we),
      .wr_addr (VecAw'(q_cmd.column)),
      .wr_data (q_cmd.value),
      .rd_en   (s1_ff),
      .rd_addr (VecAw'(slot_rdata.column)),
      .rd_data (vec_rdata)
   );

   assign pop   = (state_ff == ST_IDLE) && q_valid;
   assign issue = (state_ff == ST_RUN) && (j_ff < lim_ff);
   assign back_status.pop      = pop;
   assign back_status.clearing = (state_ff == ST_CLEAR);

   // Store writes: clearing pass or loads.
   always_comb begin
      slot_we    = 1'b0;
      vec_we     = 1'b0;
      slot_waddr = SlotAw'(q_cmd.addr);
      slot_wdata.used   = q_cmd.slot_used;
      slot_wdata.column = q_cmd.column;
      slot_wdata.value  = q_cmd.value;
      if (state_ff == ST_CLEAR) begin
         slot_we    = 1'b1;
         slot_waddr = clr_ff;
         slot_wdata = '0;
      end else if (pop) begin
         slot_we = (q_cmd.op == esmv_pkg::OP_SLOT);
         vec_we  = (q_cmd.op == esmv_pkg::OP_VECTOR);
      end
   end

   // Accumulate with floor shift and saturation.
   assign s2_use  = s1_ff && slot_rdata.used && (32'(slot_rdata.column) < MAX_COLS);
   assign prod_q  = s3_prod_ff[63:16];
   assign acc     = {sum_ff[47], sum_ff} + {prod_q[47], prod_q};
   always_comb begin
      if (acc[48] != acc[47]) begin
         acc_sat = acc[48] ? esmv_pkg::SUM_MIN : esmv_pkg::SUM_MAX;
      end else begin
         acc_sat = acc[47:0];
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      base_in      = base_ff;
      lim_in       = lim_ff;
      j_in         = j_ff;
      row_in       = row_ff;
      err_in       = err_ff;
      sum_in       = sum_ff;
      s1_in        = issue;
      s2_in        = s2_use;
      s3_in        = s2_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (s3_ff) begin
         sum_in = acc_sat;
      end
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == SlotDepth - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (pop && (q_cmd.op == esmv_pkg::OP_ROW)) begin
               base_in = SlotAw'(q_cmd.addr);
               lim_in  = q_cmd.slot_lim;
               row_in  = q_cmd.row;
               err_in  = q_cmd.size_err;
               sum_in  = '0;
               j_in    = '0;
               if (q_cmd.size_err || (q_cmd.slot_lim == '0)) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (issue) begin
               j_in = j_ff + 1'b1;
            end else if (!s1_ff && !s2_ff && !s3_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.row_index  = row_ff;
               rsp_data_in.row_sum    = sum_ff;
               rsp_data_in.size_error = err_ff;
               state_in               = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         s1_ff        <= 1'b0;
         s2_ff        <= 1'b0;
         s3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         s3_ff        <= s3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff     <= base_in;
      lim_ff      <= lim_in;
      j_ff        <= j_in;
      row_ff      <= row_in;
      err_ff      <= err_in;
      sum_ff      <= sum_in;
      s2_val_ff   <= slot_rdata.value;
      s3_prod_ff  <= s2_val_ff * $signed(vec_rdata);
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // No command is taken while the used marks are being cleared.
   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !pop)
      else $error("command popped during clearing pass");

   // A product reaches the accumulator only from a slot read that passed the s1 and s2 registers.
   a_mac_from_read: assert property (@(posedge clock) disable iff (reset)
      s3_ff |-> $past(s1_ff, 2))
      else $error("accumulate without a slot read");

   // Slot reads are only issued while a row runs and never overlap a load.
   a_issue_no_write: assert property (@(posedge clock) disable iff (reset)
      issue |-> (!slot_we && !vec_we))
      else $error("slot read collides with a store write");

   // The pipeline is empty when a row result is offered.
   a_done_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (!s1_ff && !s2_ff && !s3_ff))
      else $error("result offered with slots still in flight");

endmodule
`default_nettype wire

### hdl/ell_sparse_matrix_vector_multiply.sv
`default_nettype none
// A load is written in the cycle after acceptance when the back end is idle, later
// when it waits behind a running row; a compute result is offered once the row's slots
// (the smaller of slots_per_row and MAX_SLOTS) are accumulated. Loads go at one per
// cycle while the back end is idle; a compute holds it until its result is offered.
// Reset: synchronous; afterwards all MAX_ROWS * MAX_SLOTS slot store entries (16384 by
// default) are swept with req_stall high; configuration writes work throughout.
// ----------------------------------------------------------------------------
// ELLPACK sparse matrix-vector multiply
// Loads matrix slots and vector elements and returns saturated row sums.
// ----------------------------------------------------------------------------
module ell_sparse_matrix_vector_multiply #(
   parameter int MAX_ROWS  = esmv_pkg::MAX_ROWS_DEF,
   parameter int MAX_SLOTS = esmv_pkg::MAX_SLOTS_DEF,
   parameter int MAX_COLS  = esmv_pkg::MAX_COLS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire esmv_pkg::req_type       req_data,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output esmv_pkg::rsp_type            rsp_data,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [1:0]              csr_index,
   input  wire logic [esmv_pkg::CsrWidth-1:0] csr_data
);

   logic                      q_valid;
   esmv_pkg::cmd_type         q_cmd;
   esmv_pkg::back_status_type back_status;

   // Front end: configuration, classification and command queue.
   esmv_front #(.MAX_ROWS(MAX_ROWS), .MAX_SLOTS(MAX_SLOTS), .MAX_COLS(MAX_COLS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .q_valid     (q_valid),
      .q_cmd       (q_cmd),
      .back_status (back_status)
   );

   // Back end: stores and multiply-accumulate.
   esmv_back #(.MAX_ROWS(MAX_ROWS), .MAX_SLOTS(MAX_SLOTS), .MAX_COLS(MAX_COLS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_cmd       (q_cmd),
      .back_status (back_status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
`default_nettype wire
